// ===== design/pli_pkg.sv =====
// pli_pkg: shared types and constants of the piecewise linear interpolator.
// No dependencies; imported by the unit, the result checker and the test.
`timescale 1ns / 1ps

package pli_pkg;

  // Default table depth
  localparam int POINTS_DEF = 8;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;
  localparam int COUNT_W = 4;

  // Reset value of the points-in-use register
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(5);

  // Quotient bits kept by the divider; anything wider saturates the result
  localparam int QUOT_W = 35;
  localparam int QCNT_W = $clog2(QUOT_W);

  localparam logic signed [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_CHK0  = 15'b000000000000010,
    ST_CHKHI = 15'b000000000000100,
    ST_SRCH  = 15'b000000000001000,
    ST_CMP   = 15'b000000000010000,
    ST_F0    = 15'b000000000100000,
    ST_F1    = 15'b000000001000000,
    ST_DIFF  = 15'b000000010000000,
    ST_MAG   = 15'b000000100000000,
    ST_MUL   = 15'b000001000000000,
    ST_DINIT = 15'b000010000000000,
    ST_DIV   = 15'b000100000000000,
    ST_FIN   = 15'b001000000000000,
    ST_SPARE = 15'b010000000000000,
    ST_SPAR2 = 15'b100000000000000
  } state_t;

endpackage

// ===== design/piecewise_linear_interpolator_unit.sv =====
// piecewise_linear_interpolator_unit: breakpoint table with binary search and
// linear interpolation in signed Q16.16. Depends on pli_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_ready  func, entry_index, x_value, y_value
// out       out  out_valid/out_ready y_out, segment_index, flat_segment, saturated
// cfg       in   cfg_we             cfg_wdata (points in use)
//
// A write word produces no result and leaves the sequencer idle. A query word
// passes the range checks (CHK0, CHKHI), the binary-search steps of SRCH and
// CMP, up to log2 of the points in use minus one, rounded up, then a closing
// SRCH, the segment fetch and preparation (F0, F1, DIFF, MAG), the multiply and
// divider setup (MUL, DINIT), the bit-serial divider (DIV) and the result load
// (FIN). A query outside the table skips the search; a flat segment or an
// oversized quotient skips the divider. Reset is synchronous, active low,
// clears the sequencer and the output valid, and loads five into the
// points-in-use register; the memories need no clearing.
// A result waiting in the output register does not block the next input word;
// a finished query holds only if the output register is still occupied.

module piecewise_linear_interpolator_unit
  import pli_pkg::*;
#(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [DATA_W-1:0]  in_x_value,
  input  logic signed [DATA_W-1:0]  in_y_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_y_out,
  output logic [IDX_W-1:0]          out_segment_index,
  output logic                      out_flat_segment,
  output logic                      out_saturated,
  // configuration
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(POINTS);

  // Breakpoint memories, one synchronous read port each
  logic signed [DATA_W-1:0] mem_x [POINTS];
  logic signed [DATA_W-1:0] mem_y [POINTS];

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic [COUNT_W-1:0] points_r;

  logic [AW-1:0] rd_addr;
  logic signed [DATA_W-1:0] rd_x_r, rd_y_r;

  logic signed [DATA_W-1:0] xq_r, x1_r, y1_r;
  logic [AW-1:0] lo_r, hi_r, mid_r, seg_r;
  logic signed [DATA_W:0] dx_r, dy_r, dt_r;
  logic [DATA_W-1:0] mdx_r, mdy_r, mdt_r;
  logic neg_r, flat_r, ovf_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] rem_r;
  logic [QUOT_W-1:0] num_r;
  logic [QCNT_W-1:0] cnt_r;

  logic signed [DATA_W-1:0] y_out_r;
  logic [IDX_W-1:0] seg_out_r;
  logic flat_out_r, sat_out_r;

  logic in_acc, wr_en, fin_go;
  logic [AW-1:0] nm1, nm2, mid, seg_p1;
  logic [AW:0] mid_sum;
  int n_int;

  logic [DATA_W:0] div_try;
  logic div_ge;
  logic signed [QUOT_W+1:0] q_s, sum_s;

  logic signed [DATA_W-1:0] res_y;
  logic res_sat;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (in_func == FUNC_WRITE) &&
                     (int'(in_entry_index) < POINTS);
  assign out_valid = out_valid_r;
  assign fin_go    = !out_valid_r || out_ready;

  // Clamp points in use to between two and the table depth
  always_comb begin
    n_int = int'(points_r);
    if (n_int < 2) begin
      n_int = 2;
    end else if (n_int > POINTS) begin
      n_int = POINTS;
    end
    nm1 = AW'(n_int - 1);
    nm2 = AW'(n_int - 2);
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign seg_p1  = seg_r + AW'(1);

  // Read address: entry 0 while idle, so a query finds x[0] ready
  always_comb begin
    unique case (state_r)
      ST_CHK0: rd_addr = hi_r;
      ST_SRCH: rd_addr = mid;
      ST_F0:   rd_addr = seg_r;
      ST_F1:   rd_addr = seg_p1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[AW'(in_entry_index)] <= in_x_value;
    end
    rd_x_r <= mem_x[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_y[AW'(in_entry_index)] <= in_y_value;
    end
    rd_y_r <= mem_y[rd_addr];
  end

  // Restoring divider step: one quotient bit per cycle
  assign div_try = {rem_r, num_r[QUOT_W-1]};
  assign div_ge  = div_try >= {1'b0, mdx_r};

  // Result: clip y1 +/- q to 32 bits
  assign q_s   = $signed({2'b00, num_r});
  assign sum_s = (QUOT_W+2)'(y1_r) + (neg_r ? -q_s : q_s);

  always_comb begin
    res_y   = y1_r;
    res_sat = 1'b0;
    if (!flat_r) begin
      if (ovf_r) begin
        res_y   = neg_r ? Y_MIN : Y_MAX;
        res_sat = 1'b1;
      end else if (sum_s > (QUOT_W+2)'(Y_MAX)) begin
        res_y   = Y_MAX;
        res_sat = 1'b1;
      end else if (sum_s < (QUOT_W+2)'(Y_MIN)) begin
        res_y   = Y_MIN;
        res_sat = 1'b1;
      end else begin
        res_y   = sum_s[DATA_W-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_QUERY) state_nxt = ST_CHK0;
      end
      ST_CHK0:  state_nxt = (xq_r < rd_x_r) ? ST_F0 : ST_CHKHI;
      ST_CHKHI: state_nxt = (xq_r > rd_x_r) ? ST_F0 : ST_SRCH;
      ST_SRCH:  state_nxt = ((hi_r - lo_r) > AW'(1)) ? ST_CMP : ST_F0;
      ST_CMP:   state_nxt = ST_SRCH;
      ST_F0:    state_nxt = ST_F1;
      ST_F1:    state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MAG;
      ST_MAG:   state_nxt = (dx_r == '0) ? ST_FIN : ST_MUL;
      ST_MUL:   state_nxt = ST_DINIT;
      ST_DINIT: begin
        state_nxt = (DATA_W'(prod_r[2*DATA_W-1:QUOT_W]) >= mdx_r) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == QCNT_W'(QUOT_W - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      points_r    <= COUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        points_r <= cfg_wdata;
      end
      if (state_r == ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        xq_r <= in_x_value;
        lo_r <= '0;
        hi_r <= nm1;
      end
      ST_CHK0: begin
        if (xq_r < rd_x_r) seg_r <= '0;
      end
      ST_CHKHI: begin
        if (xq_r > rd_x_r) seg_r <= nm2;
      end
      ST_SRCH: begin
        mid_r <= mid;
        seg_r <= lo_r;
      end
      ST_CMP: begin
        if (rd_x_r > xq_r) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r;
        end
      end
      ST_F0: begin
      end
      ST_F1: begin
        x1_r <= rd_x_r;
        y1_r <= rd_y_r;
      end
      ST_DIFF: begin
        dx_r <= (DATA_W+1)'(rd_x_r) - (DATA_W+1)'(x1_r);
        dy_r <= (DATA_W+1)'(rd_y_r) - (DATA_W+1)'(y1_r);
        dt_r <= (DATA_W+1)'(xq_r) - (DATA_W+1)'(x1_r);
      end
      ST_MAG: begin
        mdx_r  <= dx_r[DATA_W] ? DATA_W'(-dx_r) : DATA_W'(dx_r);
        mdy_r  <= dy_r[DATA_W] ? DATA_W'(-dy_r) : DATA_W'(dy_r);
        mdt_r  <= dt_r[DATA_W] ? DATA_W'(-dt_r) : DATA_W'(dt_r);
        neg_r  <= dx_r[DATA_W] ^ dy_r[DATA_W] ^ dt_r[DATA_W];
        flat_r <= (dx_r == '0);
        ovf_r  <= 1'b0;
      end
      ST_MUL: begin
        prod_r <= mdy_r * mdt_r;
      end
      ST_DINIT: begin
        // a high part at or above the divisor means a quotient too wide
        ovf_r <= DATA_W'(prod_r[2*DATA_W-1:QUOT_W]) >= mdx_r;
        rem_r <= DATA_W'(prod_r[2*DATA_W-1:QUOT_W]);
        num_r <= prod_r[QUOT_W-1:0];
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_ge ? DATA_W'(div_try - {1'b0, mdx_r}) : div_try[DATA_W-1:0];
        num_r <= {num_r[QUOT_W-2:0], div_ge};
        cnt_r <= cnt_r + QCNT_W'(1);
      end
      ST_FIN: begin
        if (fin_go) begin
          y_out_r    <= res_y;
          seg_out_r  <= IDX_W'(seg_r);
          flat_out_r <= flat_r;
          sat_out_r  <= res_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_y_out         = y_out_r;
  assign out_segment_index = seg_out_r;
  assign out_flat_segment  = flat_out_r;
  assign out_saturated     = sat_out_r;

endmodule

// ===== tb/pli_result_checker.sv =====
// pli_result_checker: watches the word and result channels of the piecewise
// linear interpolator, predicts each query result and compares. Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_result_checker
  import pli_pkg::*;
#(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_func,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [DATA_W-1:0]  in_x_value,
  input  logic signed [DATA_W-1:0]  in_y_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DATA_W-1:0]  out_y_out,
  input  logic [IDX_W-1:0]          out_segment_index,
  input  logic                      out_flat_segment,
  input  logic                      out_saturated,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_wdata,
  output int                        pending,
  output int                        fail_count,
  output int                        checked_count,
  output int                        flat_count,
  output int                        sat_count
);

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic [IDX_W-1:0]         seg;
    logic                     flat;
    logic                     sat;
  } interp_result_t;

  logic signed [DATA_W-1:0] bp_x [POINTS];
  logic signed [DATA_W-1:0] bp_y [POINTS];
  logic [COUNT_W-1:0]       points_cfg;
  interp_result_t           expected_results [$];
  interp_result_t           want;
  int                       fails = 0;
  int                       checked = 0;
  int                       flats = 0;
  int                       sats = 0;

  // Clamp the register to 2..POINTS
  function automatic int unsigned active_points(input logic [COUNT_W-1:0] count);
    int unsigned n;
    n = count;
    if (n < 2) n = 2;
    if (n > POINTS) n = POINTS;
    return n;
  endfunction

  function automatic int unsigned locate_segment(input logic signed [DATA_W-1:0] xq,
                                                 input int unsigned n);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n - 1;
    if (xq < bp_x[0]) return 0;
    if (xq > bp_x[hi]) return n - 2;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (bp_x[mid] > xq) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic interp_result_t interpolate_query(input logic signed [DATA_W-1:0] xq);
    interp_result_t r;
    int unsigned seg;
    longint x1, y1, x2, y2, dx, dy, dt, acc;
    longint unsigned mdx, mdy, mdt, quo;
    logic neg;
    seg = locate_segment(xq, active_points(points_cfg));
    x1 = bp_x[seg];
    y1 = bp_y[seg];
    x2 = bp_x[seg + 1];
    y2 = bp_y[seg + 1];
    dx = x2 - x1;
    dy = y2 - y1;
    dt = longint'(xq) - x1;
    r.seg  = IDX_W'(seg);
    r.flat = 1'b0;
    r.sat  = 1'b0;
    if (dx == 0) begin
      // flat segment returns the lower y unclipped
      r.flat = 1'b1;
      r.y    = DATA_W'(y1);
    end else begin
      mdx = (dx < 0) ? -dx : dx;
      mdy = (dy < 0) ? -dy : dy;
      mdt = (dt < 0) ? -dt : dt;
      // exact product first, then truncating division
      quo = (mdy * mdt) / mdx;
      neg = ((dy < 0) != (dt < 0)) != (dx < 0);
      if (quo > (64'd1 << 34)) begin
        r.sat = 1'b1;
        r.y   = neg ? Y_MIN : Y_MAX;
      end else begin
        acc = neg ? y1 - longint'(quo) : y1 + longint'(quo);
        if (acc > longint'(Y_MAX)) begin
          r.sat = 1'b1;
          r.y   = Y_MAX;
        end else if (acc < longint'(Y_MIN)) begin
          r.sat = 1'b1;
          r.y   = Y_MIN;
        end else begin
          r.y = DATA_W'(acc);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      points_cfg = COUNT_RST;
      for (int i = 0; i < POINTS; i++) begin
        bp_x[i] = '0;
        bp_y[i] = '0;
      end
    end else begin
      // retire the result first, then take the word of this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with no query outstanding");
          fails++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.flat) flats++;
          if (want.sat) sats++;
          if (out_y_out !== want.y) begin
            $error("y_out mismatch: expected %0d, actual %0d", want.y, out_y_out);
            fails++;
          end
          if (out_segment_index !== want.seg) begin
            $error("segment_index mismatch: expected %0d, actual %0d",
                   want.seg, out_segment_index);
            fails++;
          end
          if (out_flat_segment !== want.flat) begin
            $error("flat_segment mismatch: expected %0d, actual %0d",
                   want.flat, out_flat_segment);
            fails++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, out_saturated);
            fails++;
          end
        end
      end
      if (cfg_we) points_cfg = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WRITE) begin
          if (in_entry_index < POINTS) begin
            bp_x[in_entry_index] = in_x_value;
            bp_y[in_entry_index] = in_y_value;
          end
        end else begin
          expected_results.push_back(interpolate_query(in_x_value));
        end
      end
    end
    pending       <= expected_results.size();
    fail_count    <= fails;
    checked_count <= checked;
    flat_count    <= flats;
    sat_count     <= sats;
  end

endmodule

// ===== tb/piecewise_linear_interpolator_unit_test.sv =====
// piecewise_linear_interpolator_unit_test: stimulus and verdict for the
// piecewise linear interpolator. Depends on pli_pkg and pli_result_checker.
`timescale 1ns / 1ps

// The run writes breakpoint tables and queries them. A short directed part
// hits exact breakpoints, flat segments, extrapolation below and above the
// table, saturation to both limits and an unsorted table. The random part
// then walks through a list of points-in-use settings (clamped extremes
// included), each with one of four idling patterns, reloading tables of several
// shapes and mixing in stray entry writes. The checker beside the block
// predicts and compares; this module only drives words and gives the verdict.

module piecewise_linear_interpolator_unit_test;
  import pli_pkg::*;

  localparam int N_PHASES         = 10;
  localparam int WORDS_PER_PHASE  = 58;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int CYCLE_LIMIT      = 400000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_func = FUNC_WRITE;
  logic [IDX_W-1:0]         in_entry_index = '0;
  logic signed [DATA_W-1:0] in_x_value = '0;
  logic signed [DATA_W-1:0] in_y_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_y_out;
  logic [IDX_W-1:0]         out_segment_index;
  logic                     out_flat_segment;
  logic                     out_saturated;
  logic                     cfg_we = 1'b0;
  logic [COUNT_W-1:0]       cfg_wdata = '0;

  int pending;
  int fail_count;
  int checked_count;
  int flat_count;
  int sat_count;

  // Idling knobs: the sender reads idle_pct itself, the receiver reads stall_pct
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int cycle_count = 0;

  // Stimulus-side copy of the table, used only to aim queries
  logic signed [DATA_W-1:0] table_x [POINTS_DEF];
  logic [COUNT_W-1:0]       cur_points = COUNT_RST;
  int                       writes_sent = 0;
  int                       queries_sent = 0;
  int unsigned              point_settings [N_PHASES] = '{8, 2, 15, 0, 3, 1, 6, 7, 5, 4};

  always #10 clk = ~clk;

  piecewise_linear_interpolator_unit #(.POINTS(POINTS_DEF)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_x_value        (in_x_value),
    .in_y_value        (in_y_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_y_out         (out_y_out),
    .out_segment_index (out_segment_index),
    .out_flat_segment  (out_flat_segment),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  pli_result_checker #(.POINTS(POINTS_DEF)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_x_value        (in_x_value),
    .in_y_value        (in_y_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_y_out         (out_y_out),
    .out_segment_index (out_segment_index),
    .out_flat_segment  (out_flat_segment),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .pending           (pending),
    .fail_count        (fail_count),
    .checked_count     (checked_count),
    .flat_count        (flat_count),
    .sat_count         (sat_count)
  );

  // Watchdog: a hung handshake or a missing result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  // The hold is counted here so the sender keeps offering words meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word and return at the edge that accepts it. Valid stays high
  // on return; drop it only when an idle gap is drawn, never in the same step
  // that raises it again.
  task automatic send_word(input logic f, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_entry_index <= idx;
    in_x_value     <= x;
    in_y_value     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y);
    table_x[idx] = x;
    writes_sent++;
    send_word(FUNC_WRITE, idx, x, y);
  endtask

  // y_value is ignored on a query, so fill it with noise
  task automatic query(input logic signed [DATA_W-1:0] x);
    queries_sent++;
    send_word(FUNC_QUERY, IDX_W'($urandom), x, $urandom);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_points(input logic [COUNT_W-1:0] count);
    drain_results();
    cfg_we     <= 1'b1;
    cfg_wdata  <= count;
    cur_points = count;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 54; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 54; end
      default: begin idle_pct = 30; stall_pct <= 30; end
    endcase
  endtask

  function automatic int active_count();
    int n;
    n = cur_points;
    if (n < 2) n = 2;
    if (n > POINTS_DEF) n = POINTS_DEF;
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_y();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return DATA_W'($urandom_range(1 << 21) - (1 << 20));
    if (pick == 3) return $urandom_range(1) ? Y_MAX : Y_MIN;
    return $urandom;
  endfunction

  // Reload all eight entries with one of several shapes: wide sorted,
  // narrow steps, tight cluster, unsorted, sorted with a repeated x.
  task automatic load_table();
    logic signed [DATA_W-1:0] xs [POINTS_DEF];
    logic signed [DATA_W-1:0] tmp;
    int shape, first, dup;
    shape = $urandom_range(4);
    for (int i = 0; i < POINTS_DEF; i++) begin
      case (shape)
        1: xs[i] = (i == 0) ? ($signed($urandom) >>> 4)
                            : xs[i-1] + DATA_W'($urandom_range(1 << 18, 1));
        2: xs[i] = DATA_W'($urandom_range(1 << 21) - (1 << 20));
        default: xs[i] = $urandom;
      endcase
    end
    if (shape != 1 && shape != 3) begin
      for (int i = 1; i < POINTS_DEF; i++) begin
        tmp = xs[i];
        for (int j = i - 1; j >= 0; j--) begin
          if (xs[j] > tmp) begin
            xs[j+1] = xs[j];
            xs[j]   = tmp;
          end
        end
      end
    end
    if (shape == 4) begin
      dup = $urandom_range(POINTS_DEF - 2);
      xs[dup+1] = xs[dup];
    end
    // write in a rotated order so every index comes first now and then
    first = $urandom_range(POINTS_DEF - 1);
    for (int k = 0; k < POINTS_DEF; k++) begin
      write_entry(IDX_W'((first + k) % POINTS_DEF), xs[(first + k) % POINTS_DEF], random_y());
    end
  endtask

  // Aim mostly inside the active span, sometimes at a breakpoint, beyond
  // either end, at the limits, or anywhere at all.
  function automatic logic signed [DATA_W-1:0] pick_query_x(input int n);
    longint lo, hi, span;
    longint unsigned r;
    lo = table_x[0];
    hi = table_x[n-1];
    if (hi < lo) begin
      span = lo;
      lo   = hi;
      hi   = span;
    end
    span = hi - lo;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: return DATA_W'(lo + longint'(r % longint'(span + 1)));
      4, 5: return table_x[$urandom_range(n - 1)];
      6: return DATA_W'(lo - longint'(r % (64'd1 << $urandom_range(31))) - 1);
      7: return DATA_W'(hi + longint'(r % (64'd1 << $urandom_range(31))) + 1);
      8: return $urandom_range(1) ? Y_MAX : Y_MIN;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int pick;
    int words;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(0);

    // Directed: reset count is five, so entries 0..4 are live.
    // Entries 3 and 4 share x, which makes the top segment flat.
    write_entry(0, Y_MIN, 0);
    write_entry(1, -Q_ONE, Q_ONE);
    write_entry(2, 0, Y_MAX);
    write_entry(3, Q_ONE, 0);
    write_entry(4, Q_ONE, -Q_ONE);
    write_entry(5, 3 * Q_ONE, 2 * Q_ONE);
    write_entry(6, 5 * Q_ONE, Y_MIN);
    write_entry(7, Y_MAX, Y_MAX);
    query(Y_MIN);          // exactly on the first breakpoint
    query(-(Q_ONE / 2));   // rising segment
    query(Q_ONE / 2);      // falling segment
    query(Q_ONE);          // lands on the flat segment
    query(Y_MAX);          // above the table, flat last segment
    query(0);              // exactly on an interior breakpoint
    // Steep last segment: extrapolating up clips to the low limit
    write_entry(4, 2 * Q_ONE, Y_MIN);
    query(Y_MAX);
    query(Q_ONE + Q_ONE / 2);
    // Steep first segment: extrapolating down clips to the high limit
    write_entry(0, -2 * Q_ONE, Y_MAX);
    write_entry(1, -Q_ONE, Y_MIN);
    query(Y_MIN);
    query(-Q_ONE - Q_ONE / 2);
    // Unsorted table: search and arithmetic run on whatever is stored
    write_entry(2, -5 * Q_ONE, 7);
    query(-(Q_ONE / 2));

    // Random phases, one points-in-use setting and one idling pattern each
    point_settings[N_PHASES-1] = $urandom_range(15);
    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_points(COUNT_W'(point_settings[phase]));
      set_idle(phase % 4);
      // Fill the block: hold the result side off while words keep coming
      if (phase == 4) hold_requests <= hold_requests + 1;
      words = writes_sent + queries_sent;
      load_table();
      while (writes_sent + queries_sent - words < WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 6) load_table();
        else if (pick < 14) write_entry(IDX_W'($urandom), $urandom, random_y());
        else query(pick_query_x(active_count()));
      end
    end

    drain_results();
    $display("Covered %0d table writes and %0d queries over %0d count settings.",
             writes_sent, queries_sent, N_PHASES + 1);
    $display("Checked %0d results, %0d on flat segments and %0d saturated.",
             checked_count, flat_count, sat_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pli_pkg.sv
design/piecewise_linear_interpolator_unit.sv
tb/pli_result_checker.sv
tb/piecewise_linear_interpolator_unit_test.sv
